// ===== src/assert_macros.svh =====
// assertion macros used by the square root controller
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/isqrt_pkg.sv =====
// shared types and constants for the integer square root block
// no dependencies
package isqrt_pkg;

    localparam int ROOT_W = 16;
    localparam logic [ROOT_W-1:0] ROOT_MAX = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } isqrt_cmd_t;

endpackage

// ===== src/isqrt_ctrl.sv =====
// controller: sequences one bit-pair step per cycle and raises the result strobe
// depends on isqrt_pkg and assert_macros.svh
`include "assert_macros.svh"

module isqrt_ctrl #(
    parameter int ROOT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output isqrt_pkg::isqrt_cmd_t cmd
);
    import isqrt_pkg::*;

    localparam int CNT_W = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_BITS - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             accept;
    logic             last;

    assign accept = start && (state_reg == S_IDLE);
    assign last   = (cnt_reg == CNT_LAST);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    cnt_next   = '0;
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == S_RUN);
    assign done     = done_reg;
    assign cmd.load = accept;
    assign cmd.step = (state_reg == S_RUN);
    assign cmd.last = (state_reg == S_RUN) && last;

    `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transfer did not start work")
    `ASSERT_NEXT(a_last_done, cmd.last, done && !busy, "strobe missing after final step")
    `ASSERT_IMPL(a_done_idle, done, !busy && $past(cmd.last), "strobe without final step")

endmodule

// ===== src/isqrt_dp.sv =====
// datapath: operand shifter, remainder and partial root, result register
// depends on isqrt_pkg
module isqrt_dp #(
    parameter int OPERAND_WIDTH = 32,
    parameter int ROOT_BITS     = 16
) (
    input  logic                          clk,
    input  logic [OPERAND_WIDTH-1:0]      value,
    input  isqrt_pkg::isqrt_cmd_t         cmd,
    output logic [isqrt_pkg::ROOT_W-1:0]  root
);
    import isqrt_pkg::*;

    localparam int OP_W  = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS + 2;
    localparam int WIDE_W = ROOT_BITS + ROOT_W;

    logic [OP_W-1:0]      op_reg;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ROOT_BITS-1:0] part_reg, part_next;
    logic [ROOT_W-1:0]    root_reg;
    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     trial;
    logic [REM_W:0]       diff;
    logic                 fits;
    logic [WIDE_W-1:0]    wide;

    assign rem_shift = {rem_reg[REM_W-3:0], op_reg[OP_W-1 -: 2]};
    assign trial     = {part_reg, 2'b01};
    assign diff      = {1'b0, rem_shift} - {1'b0, trial};
    assign fits      = !diff[REM_W];

    always_comb
    begin
        if (fits)
        begin
            rem_next  = diff[REM_W-1:0];
            part_next = {part_reg[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            part_next = {part_reg[ROOT_BITS-2:0], 1'b0};
        end
        wide = WIDE_W'(part_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= value[OPERAND_WIDTH-1] ? '0 : OP_W'(value);
            rem_reg  <= '0;
            part_reg <= '0;
        end
        else if (cmd.step)
        begin
            op_reg   <= {op_reg[OP_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            part_reg <= part_next;
        end
        if (cmd.last)
        begin
            if (wide > WIDE_W'(ROOT_MAX))
                root_reg <= ROOT_MAX;
            else
                root_reg <= wide[ROOT_W-1:0];
        end
    end

    assign root = root_reg;

endmodule

// ===== src/integer_square_root.sv =====
// top level of the integer square root block: controller plus datapath
// depends on isqrt_pkg, isqrt_ctrl and isqrt_dp
//
// channel   direction  handshake            payload
// request   in         start high, busy low value
// result    out        done, one cycle      root
//
// one root bit per cycle over ceil(OPERAND_WIDTH/2) steps, which begin after the accepting edge;
// no new start is taken while busy, so one item is worked on at a time
// the strobe comes in the cycle after the final step; a new start is taken in that cycle
// reset clears the controller only; the result register is undefined until the first strobe
// the receiver cannot stall; root holds its value until the next strobe
module integer_square_root #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [OPERAND_WIDTH-1:0]      value,
    output logic                          busy,
    output logic                          done,
    output logic [isqrt_pkg::ROOT_W-1:0]  root
);
    import isqrt_pkg::*;

    localparam int ROOT_BITS = (OPERAND_WIDTH + 1) / 2;

    isqrt_cmd_t cmd;

    isqrt_ctrl #(
        .ROOT_BITS (ROOT_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    isqrt_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .ROOT_BITS     (ROOT_BITS)
    ) u_dp (
        .clk   (clk),
        .value (value),
        .cmd   (cmd),
        .root  (root)
    );

endmodule

// ===== dv/tb_integer_square_root.sv =====
// self-checking testbench for integer_square_root: directed table then random operands
// checks use fixed table roots or an in-bench floor square root predictor
// depends on isqrt_pkg and integer_square_root
module tb_integer_square_root;
    timeunit 1ns;
    timeprecision 1ps;

    import isqrt_pkg::*;

    localparam int OPW = 32;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic [OPW-1:0]    value;
        bit                fixed;
        logic [ROOT_W-1:0] root;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [OPW-1:0]    value = '0;
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;

    logic [ROOT_W-1:0] next_root = '0;
    logic [ROOT_W-1:0] pending_roots[$];
    int                mismatches = 0;
    int                burst_left = 0;
    dir_row_t          dir_rows[21];

    integer_square_root #(
        .OPERAND_WIDTH(OPW)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .value(value),
        .busy(busy),
        .done(done),
        .root(root)
    );

    always #1 clk = ~clk;

    function automatic logic [ROOT_W-1:0] isqrt_of(input logic [OPW-1:0] v);
        logic [OPW-1:0] rem;
        logic [OPW-1:0] acc;
        logic [OPW-1:0] one;
        rem = v;
        acc = '0;
        one = {2'b01, {(OPW-2){1'b0}}};
        if (v[OPW-1])
            return '0;
        while (one > rem)
            one = one >> 2;
        while (one != 0)
        begin
            if (rem >= acc + one)
            begin
                rem = rem - (acc + one);
                acc = (acc >> 1) + one;
            end
            else
            begin
                acc = acc >> 1;
            end
            one = one >> 2;
        end
        if (acc > OPW'(ROOT_MAX))
            return ROOT_MAX;
        return acc[ROOT_W-1:0];
    endfunction

    function automatic logic [OPW-1:0] rand_operand();
        logic [OPW-1:0] raw;
        logic [OPW-1:0] r;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0, 1: return raw;
            2: return {1'b1, raw[OPW-2:0]};
            3: return OPW'($urandom_range(0, 1000));
            4:
            begin
                r = OPW'($urandom_range(0, 46340));
                return r * r + OPW'($urandom_range(0, 2)) - 1;
            end
            5: return raw >> $urandom_range(0, OPW-1);
            6: return 32'h7FFF_FFFF - OPW'($urandom_range(0, 200000));
            default: return {1'b0, raw[OPW-2:0]};
        endcase
    endfunction

    task automatic send_operand(input logic [OPW-1:0] v, input logic [ROOT_W-1:0] r);
        start <= 1'b1;
        value <= v;
        next_root <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results(input int limit);
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending_roots.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_roots.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_roots.size());
            mismatches++;
        end
    endtask

    // pop before push: a result never belongs to the transfer taken at the same edge
    always @(posedge clk)
    begin
        logic [ROOT_W-1:0] want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_roots.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d", $time, root);
                    mismatches++;
                end
                else
                begin
                    want = pending_roots.pop_front();
                    if (root !== want)
                    begin
                        $display("%0t: root mismatch, expected %0d, got %0d",
                                 $time, want, root);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                pending_roots.push_back(next_root);
        end
    end

    initial
    begin
        logic [OPW-1:0] v;
        dir_rows = '{
            '{32'd0,          1'b1, 16'd0},
            '{32'd1,          1'b1, 16'd1},
            '{32'd2,          1'b1, 16'd1},
            '{32'd3,          1'b1, 16'd1},
            '{32'd4,          1'b1, 16'd2},
            '{32'd4096,       1'b1, 16'd64},
            '{32'd16383,      1'b1, 16'd127},
            '{32'd16384,      1'b1, 16'd128},
            '{32'd36864,      1'b1, 16'd192},
            '{32'd65535,      1'b1, 16'd255},
            '{32'd65536,      1'b1, 16'd256},
            '{32'd119715,     1'b1, 16'd345},
            '{32'd119716,     1'b1, 16'd346},
            '{32'd1000000,    1'b1, 16'd1000},
            '{32'd2147395599, 1'b1, 16'd46339},
            '{32'd2147395600, 1'b1, 16'd46340},
            '{32'h7FFF_FFFF,  1'b1, 16'd46340},
            '{32'h8000_0000,  1'b1, 16'd0},
            '{32'hFFFF_FFFF,  1'b1, 16'd0},
            '{32'h5555_5555,  1'b0, 16'd0},
            '{32'd12345678,   1'b0, 16'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if ($urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 20));
            send_operand(dir_rows[i].value,
                         dir_rows[i].fixed ? dir_rows[i].root : isqrt_of(dir_rows[i].value));
        end
        drain_results(2000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_results(2000);
            if (burst_left == 0)
            begin
                idle_for($urandom_range(1, 20));
                burst_left = $urandom_range(1, 40);
            end
            v = rand_operand();
            send_operand(v, isqrt_of(v));
            burst_left--;
        end

        drain_results(2000);
        repeat (24) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #800000;
        $display("%0t: run timed out", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
